// ===== hw/rtl/hns_pkg.sv =====
package hns_pkg;

    // Reset values of the configuration registers.
    localparam logic [10:0] GRID_SIDE_RST    = 11'd64;
    localparam logic [15:0] HEIGHT_SCALE_RST = 16'd256;

    // Default largest grid side that the row stores hold.
    localparam int MAX_SIDE_DEF = 1024;

    // Configuration port geometry.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // ceil(2^32 / 255): exact floor division by 255 for products below 2^24.
    localparam logic [24:0] RECIP_255 = 25'd16843010;

    // Square of the constant z term, 2.0 in Q8.8.
    localparam logic [31:0] Z_SQ = 32'd262144;

    // Register index on the configuration port.
    typedef enum logic [0:0] {
        REG_GRID_SIDE    = 1'b0,
        REG_HEIGHT_SCALE = 1'b1
    } t_reg_idx;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PROD,
        ST_HGT,
        ST_RD_L,
        ST_RD_C,
        ST_RD_R,
        ST_RD_END,
        ST_WR_PREV,
        ST_WR_CUR,
        ST_NEXT,
        ST_SETUP,
        ST_SQX,
        ST_SQY,
        ST_LEN,
        ST_MAG_GO,
        ST_MAG_WAIT,
        ST_OUT,
        ST_UPD
    } t_state;

    // Which normal is being formed for the current input.
    typedef enum logic [1:0] {
        K_UP,   // center one row above the new vertex
        K_PREV, // left neighbor on the final row
        K_LAST  // final vertex of the frame
    } t_kind;

    // Component handled by the magnitude unit.
    typedef enum logic [1:0] {
        C_X,
        C_Y,
        C_Z
    } t_comp;

    // Row store read slot.
    typedef enum logic [1:0] {
        RD_L,
        RD_C,
        RD_R
    } t_rdsel;

    // Row store write slot.
    typedef enum logic [0:0] {
        WR_PREV,
        WR_CUR
    } t_wrsel;

    // Commands from controller to datapath.
    typedef struct packed {
        logic   accept;
        logic   prod;
        logic   hgt;
        logic   rd_en;
        t_rdsel rd_sel;
        logic   cap_en;
        t_rdsel cap_sel;
        logic   wr_en;
        t_wrsel wr_sel;
        logic   setup;
        t_kind  kind;
        logic   sqx;
        logic   sqy;
        logic   len;
        logic   mag_start;
        t_comp  comp;
        logic   mag_cap;
        logic   out_load;
        logic   upd;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic has_up;
        logic has_prev;
        logic has_last;
        logic mag_done;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/hns_in_if.sv =====
interface hns_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] gray;

    modport source (output valid, output gray, input ready);
    modport sink (input valid, input gray, output ready);
endinterface

// ===== hw/rtl/hns_out_if.sv =====
interface hns_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic        [14:0] norm_z;
    logic        [9:0]  col_index;
    logic        [9:0]  row_index;
    logic               last;

    modport source (
        output valid, output norm_x, output norm_y, output norm_z,
        output col_index, output row_index, output last, input ready
    );
    modport sink (
        input valid, input norm_x, input norm_y, input norm_z,
        input col_index, input row_index, input last, output ready
    );
endinterface

// ===== hw/rtl/hns_cfg_regs.sv =====
module hns_cfg_regs #(
    parameter int MAX_SIDE = hns_pkg::MAX_SIDE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hns_pkg::PADDR_W-1:0]       paddr,
    input  logic [hns_pkg::PDATA_W-1:0]       pwdata,
    output logic [hns_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    output logic [15:0]                       o_height_scale,
    output logic [$clog2(MAX_SIDE)-1:0]       o_side_last,
    output logic                              o_clear
);
    import hns_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int GW = (CW + 1 > 11) ? CW + 1 : 11;
    localparam logic [GW-1:0] SIDE_MAX = GW'(MAX_SIDE);
    localparam logic [GW-1:0] SIDE_MIN = GW'(2);

    logic [10:0]   r_grid_side;
    logic [15:0]   r_height_scale;
    logic          wr;
    t_reg_idx      idx;
    logic [GW-1:0] side_ext;
    logic [GW-1:0] side_eff;
    logic [GW-1:0] side_m1;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign wr     = psel & penable & pwrite;

    // Register writes; any write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side    <= GRID_SIDE_RST;
            r_height_scale <= HEIGHT_SCALE_RST;
        end else if (wr) begin
            unique case (idx)
                REG_GRID_SIDE:    r_grid_side    <= pwdata[10:0];
                REG_HEIGHT_SCALE: r_height_scale <= pwdata[15:0];
                default:          r_grid_side    <= r_grid_side;
            endcase
        end
    end

    // Read back.
    always_comb begin
        unique case (idx)
            REG_GRID_SIDE:    prdata = PDATA_W'(r_grid_side);
            REG_HEIGHT_SCALE: prdata = PDATA_W'(r_height_scale);
            default:          prdata = '0;
        endcase
    end

    // Clamp the side into the supported range.
    always_comb begin
        side_ext = GW'(r_grid_side);
        priority if (side_ext < SIDE_MIN) begin
            side_eff = SIDE_MIN;
        end else if (side_ext > SIDE_MAX) begin
            side_eff = SIDE_MAX;
        end else begin
            side_eff = side_ext;
        end
        side_m1 = side_eff - GW'(1);
    end

    assign o_side_last    = side_m1[CW-1:0];
    assign o_height_scale = r_height_scale;
    assign o_clear        = wr;

endmodule

// ===== hw/rtl/hns_mag_unit.sv =====
module hns_mag_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_c2,
    input  logic [33:0] i_len2,
    output logic        o_done,
    output logic [14:0] o_mag
);
    // Rounded c * 16384 / sqrt(len2), one result bit per cycle.
    // With u = 2v + 1, a = u^2 * len2 is grown by shifts and adds only.

    logic        r_busy;
    logic        r_done;
    logic        r_ok;
    logic [13:0] r_v;
    logic [13:0] r_bit;
    logic [66:0] r_a;
    logic [66:0] r_bs;
    logic [66:0] r_ls;
    logic [66:0] r_rhs;
    logic [66:0] rhs_in;
    logic [66:0] a_try;
    logic        fit;

    assign rhs_in = {5'd0, i_c2, 30'd0};
    assign a_try  = r_a + r_bs + r_ls;
    assign fit    = a_try <= r_rhs;

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy & r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Search datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rhs <= rhs_in;
            r_ok  <= 67'(i_len2) <= rhs_in;
            r_a   <= 67'(i_len2);
            r_bs  <= 67'(i_len2) << 15;
            r_ls  <= 67'(i_len2) << 28;
            r_v   <= '0;
            r_bit <= 14'h2000;
        end else if (r_busy) begin
            if (fit) begin
                r_a  <= a_try;
                r_v  <= r_v | r_bit;
                r_bs <= (r_bs >> 1) + r_ls;
            end else begin
                r_bs <= r_bs >> 1;
            end
            r_ls  <= r_ls >> 2;
            r_bit <= r_bit >> 1;
        end
    end

    assign o_done = r_done;
    assign o_mag  = r_ok ? (15'(r_v) + 15'd1) : 15'd0;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("magnitude done held for more than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("magnitude done while search still running");

endmodule

// ===== hw/rtl/hns_datapath.sv =====
module hns_datapath #(
    parameter int MAX_SIDE = hns_pkg::MAX_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hns_pkg::t_cmd               i_cmd,
    output hns_pkg::t_sts               o_sts,
    input  logic [7:0]                  i_gray,
    input  logic [15:0]                 i_height_scale,
    input  logic [$clog2(MAX_SIDE)-1:0] i_side_last,
    input  logic                        i_clear,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [15:0]          o_norm_x,
    output logic signed [15:0]          o_norm_y,
    output logic [14:0]                 o_norm_z,
    output logic [9:0]                  o_col_index,
    output logic [9:0]                  o_row_index,
    output logic                        o_last
);
    import hns_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);

    // Row stores: newer holds the previous row, older the one before it.
    logic [15:0]   r_mem_new [MAX_SIDE];
    logic [15:0]   r_mem_old [MAX_SIDE];

    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [15:0]   r_cur1;
    logic [15:0]   r_cur2;
    logic [7:0]    r_gray;
    logic [23:0]   r_prod;
    logic [15:0]   r_h;
    logic [15:0]   r_rd_new;
    logic [15:0]   r_rd_old;
    logic [15:0]   r_l;
    logic [15:0]   r_c;
    logic [15:0]   r_oc;
    logic [15:0]   r_r;
    logic [16:0]   r_dx;
    logic [16:0]   r_dy;
    logic [9:0]    r_col_o;
    logic [9:0]    r_row_o;
    logic          r_last_o;
    logic [31:0]   r_ax2;
    logic [31:0]   r_ay2;
    logic [33:0]   r_len2;
    logic [14:0]   r_mx;
    logic [14:0]   r_my;
    logic [14:0]   r_mz;
    logic          r_out_valid;
    logic [15:0]   r_nx;
    logic [15:0]   r_ny;
    logic [14:0]   r_nz;
    logic [9:0]    r_ncol;
    logic [9:0]    r_nrow;
    logic          r_nlast;

    logic          x_is_last;
    logic          y_is_last;
    logic [CW-1:0] rd_addr;
    logic [CW-1:0] wr_addr;
    logic [15:0]   wr_new;
    logic [15:0]   wr_old;
    logic          wr_go;
    logic [15:0]   s_l;
    logic [15:0]   s_r;
    logic [15:0]   s_b;
    logic [15:0]   s_t;
    logic [CW-1:0] s_col;
    logic [CW-1:0] s_row;
    logic [23:0]   prod_w;
    logic [48:0]   quot_w;
    logic [16:0]   dx_neg;
    logic [16:0]   dy_neg;
    logic [15:0]   ax;
    logic [15:0]   ay;
    logic [31:0]   mag_c2;
    logic          mag_done;
    logic [14:0]   mag;
    logic [15:0]   mx_ext;
    logic [15:0]   my_ext;

    assign x_is_last = r_col == i_side_last;
    assign y_is_last = r_row == i_side_last;

    // Height scaling: gray * scale, then floor division by 255.
    assign prod_w = 24'(r_gray) * 24'(i_height_scale);
    assign quot_w = 49'(r_prod) * 49'(RECIP_255);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_gray <= i_gray;
        if (i_cmd.prod)   r_prod <= prod_w;
        if (i_cmd.hgt)    r_h    <= quot_w[47:32];
    end

    // Row store read address with the neighbors clamped at the edges.
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_L:    rd_addr = (r_col == '0) ? r_col : r_col - CW'(1);
            RD_C:    rd_addr = r_col;
            RD_R:    rd_addr = x_is_last ? r_col : r_col + CW'(1);
            default: rd_addr = r_col;
        endcase
    end

    // Row store write: shift a column down one row.
    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_PREV: begin
                wr_addr = r_col - CW'(1);
                wr_new  = r_cur1;
                wr_old  = r_l;
                wr_go   = i_cmd.wr_en & (r_col != '0);
            end
            WR_CUR: begin
                wr_addr = r_col;
                wr_new  = r_h;
                wr_old  = r_c;
                wr_go   = i_cmd.wr_en & x_is_last;
            end
            default: begin
                wr_addr = r_col;
                wr_new  = r_h;
                wr_old  = r_c;
                wr_go   = 1'b0;
            end
        endcase
    end

    // Row store memories.
    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem_new[wr_addr] <= wr_new;
            r_mem_old[wr_addr] <= wr_old;
        end
        if (i_cmd.rd_en) begin
            r_rd_new <= r_mem_new[rd_addr];
            r_rd_old <= r_mem_old[rd_addr];
        end
    end

    // Capture of the neighbor heights.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            unique case (i_cmd.cap_sel)
                RD_L: r_l <= r_rd_new;
                RD_C: begin
                    r_c  <= r_rd_new;
                    r_oc <= r_rd_old;
                end
                RD_R:    r_r <= r_rd_new;
                default: r_l <= r_l;
            endcase
        end
    end

    // Neighbor selection for the normal being formed.
    always_comb begin
        unique case (i_cmd.kind)
            K_UP: begin
                s_l   = r_l;
                s_r   = r_r;
                s_b   = (r_row == CW'(1)) ? r_c : r_oc;
                s_t   = r_h;
                s_col = r_col;
                s_row = r_row - CW'(1);
            end
            K_PREV: begin
                s_l   = (r_col >= CW'(2)) ? r_cur2 : r_cur1;
                s_r   = r_h;
                s_b   = r_l;
                s_t   = r_cur1;
                s_col = r_col - CW'(1);
                s_row = r_row;
            end
            K_LAST: begin
                s_l   = r_cur1;
                s_r   = r_h;
                s_b   = r_c;
                s_t   = r_h;
                s_col = r_col;
                s_row = r_row;
            end
            default: begin
                s_l   = r_l;
                s_r   = r_r;
                s_b   = r_c;
                s_t   = r_h;
                s_col = r_col;
                s_row = r_row;
            end
        endcase
    end

    assign dx_neg = 17'd0 - r_dx;
    assign dy_neg = 17'd0 - r_dy;
    assign ax     = r_dx[16] ? dx_neg[15:0] : r_dx[15:0];
    assign ay     = r_dy[16] ? dy_neg[15:0] : r_dy[15:0];

    // Differences, squares and squared length.
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_dx     <= {1'b0, s_l} - {1'b0, s_r};
            r_dy     <= {1'b0, s_t} - {1'b0, s_b};
            r_col_o  <= 10'(s_col);
            r_row_o  <= 10'(s_row);
            r_last_o <= i_cmd.kind == K_LAST;
        end
        if (i_cmd.sqx) r_ax2  <= 32'(ax) * 32'(ay & 16'd0 | ax);
        if (i_cmd.sqy) r_ay2  <= 32'(ay) * 32'(ay);
        if (i_cmd.len) r_len2 <= 34'(r_ax2) + 34'(r_ay2) + 34'(Z_SQ);
    end

    // Magnitude unit, shared by the three components.
    always_comb begin
        unique case (i_cmd.comp)
            C_X:     mag_c2 = r_ax2;
            C_Y:     mag_c2 = r_ay2;
            C_Z:     mag_c2 = Z_SQ;
            default: mag_c2 = Z_SQ;
        endcase
    end

    hns_mag_unit u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mag_start),
        .i_c2    (mag_c2),
        .i_len2  (r_len2),
        .o_done  (mag_done),
        .o_mag   (mag)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.mag_cap) begin
            unique case (i_cmd.comp)
                C_X:     r_mx <= mag;
                C_Y:     r_my <= mag;
                C_Z:     r_mz <= mag;
                default: r_mz <= r_mz;
            endcase
        end
    end

    // Output register; apply the signs on load.
    assign mx_ext = {1'b0, r_mx};
    assign my_ext = {1'b0, r_my};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_nx    <= r_dx[16] ? (16'd0 - mx_ext) : mx_ext;
            r_ny    <= r_dy[16] ? (16'd0 - my_ext) : my_ext;
            r_nz    <= r_mz;
            r_ncol  <= r_col_o;
            r_nrow  <= r_row_o;
            r_nlast <= r_last_o;
        end
    end

    // Position and current-row heights.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_col  <= '0;
            r_row  <= '0;
            r_cur1 <= '0;
            r_cur2 <= '0;
        end else if (i_cmd.upd) begin
            r_cur2 <= r_cur1;
            r_cur1 <= r_h;
            if (x_is_last) begin
                r_col <= '0;
                r_row <= y_is_last ? '0 : r_row + CW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    assign o_sts.has_up   = r_row != '0;
    assign o_sts.has_prev = y_is_last & (r_col != '0);
    assign o_sts.has_last = y_is_last & x_is_last;
    assign o_sts.mag_done = mag_done;
    assign o_sts.out_free = ~r_out_valid | i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_norm_x    = r_nx;
    assign o_norm_y    = r_ny;
    assign o_norm_z    = r_nz;
    assign o_col_index = r_ncol;
    assign o_row_index = r_nrow;
    assign o_last      = r_nlast;

    a_pos_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= i_side_last) && (r_row <= i_side_last))
        else $error("grid position beyond the configured side");

endmodule

// ===== hw/rtl/hns_ctrl.sv =====
module hns_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  hns_pkg::t_sts i_sts,
    output hns_pkg::t_cmd o_cmd
);
    import hns_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_pend;
    logic [2:0] n_pend;
    t_kind      r_kind;
    t_kind      n_kind;
    t_comp      r_comp;
    t_comp      n_comp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= '0;
            r_kind  <= K_UP;
            r_comp  <= C_X;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_kind  <= n_kind;
            r_comp  <= n_comp;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        n_kind  = r_kind;
        n_comp  = r_comp;
        unique case (r_state)
            ST_IDLE:    if (i_valid) n_state = ST_PROD;
            ST_PROD:    n_state = ST_HGT;
            ST_HGT:     n_state = ST_RD_L;
            ST_RD_L:    n_state = ST_RD_C;
            ST_RD_C:    n_state = ST_RD_R;
            ST_RD_R:    n_state = ST_RD_END;
            ST_RD_END:  n_state = ST_WR_PREV;
            ST_WR_PREV: n_state = ST_WR_CUR;
            ST_WR_CUR: begin
                n_pend  = {i_sts.has_last, i_sts.has_prev, i_sts.has_up};
                n_state = ST_NEXT;
            end
            ST_NEXT: begin
                priority if (r_pend[0]) begin
                    n_kind    = K_UP;
                    n_pend[0] = 1'b0;
                    n_state   = ST_SETUP;
                end else if (r_pend[1]) begin
                    n_kind    = K_PREV;
                    n_pend[1] = 1'b0;
                    n_state   = ST_SETUP;
                end else if (r_pend[2]) begin
                    n_kind    = K_LAST;
                    n_pend[2] = 1'b0;
                    n_state   = ST_SETUP;
                end else begin
                    n_state = ST_UPD;
                end
            end
            ST_SETUP: n_state = ST_SQX;
            ST_SQX:   n_state = ST_SQY;
            ST_SQY:   n_state = ST_LEN;
            ST_LEN: begin
                n_comp  = C_X;
                n_state = ST_MAG_GO;
            end
            ST_MAG_GO: n_state = ST_MAG_WAIT;
            ST_MAG_WAIT: begin
                if (i_sts.mag_done) begin
                    unique case (r_comp)
                        C_X: begin
                            n_comp  = C_Y;
                            n_state = ST_MAG_GO;
                        end
                        C_Y: begin
                            n_comp  = C_Z;
                            n_state = ST_MAG_GO;
                        end
                        default: n_state = ST_OUT;
                    endcase
                end
            end
            ST_OUT:  if (i_sts.out_free) n_state = ST_NEXT;
            ST_UPD:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        o_cmd.comp = r_comp;
        o_ready    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            ST_PROD: o_cmd.prod = 1'b1;
            ST_HGT:  o_cmd.hgt  = 1'b1;
            ST_RD_L: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_L;
            end
            ST_RD_C: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_C;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_L;
            end
            ST_RD_R: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_R;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_C;
            end
            ST_RD_END: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_R;
            end
            ST_WR_PREV: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_PREV;
            end
            ST_WR_CUR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_CUR;
            end
            ST_SETUP:    o_cmd.setup     = 1'b1;
            ST_SQX:      o_cmd.sqx       = 1'b1;
            ST_SQY:      o_cmd.sqy       = 1'b1;
            ST_LEN:      o_cmd.len       = 1'b1;
            ST_MAG_GO:   o_cmd.mag_start = 1'b1;
            ST_MAG_WAIT: o_cmd.mag_cap   = i_sts.mag_done;
            ST_OUT:      o_cmd.out_load  = i_sts.out_free;
            ST_UPD:      o_cmd.upd       = 1'b1;
            default:     o_ready         = 1'b0;
        endcase
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("output register loaded while still occupied");

    a_upd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> (r_pend == 3'b000))
        else $error("position advanced with normals still pending");

endmodule

// ===== hw/rtl/heightmap_normal_stream.sv =====
// Channel   Dir  Handshake       Payload
// i_pix     in   valid / ready   gray
// o_nrm     out  valid / ready   norm_x norm_y norm_z col_index row_index last
// apb       in   psel / penable  paddr pwdata -> prdata (grid_side, height_scale)
//
// An input yields up to three normals; for each normal the bit-serial magnitude
// unit runs once per component. A new input is accepted only once the last one
// is done.
// Reset clears the position, the current-row heights and the registers; the
// row stores are not cleared, and no clearing pass runs.
// A stalled output holds only its own register; work goes on until the next
// normal needs that register.
module heightmap_normal_stream #(
    parameter int MAX_SIDE = hns_pkg::MAX_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    hns_in_if.sink                      i_pix,
    hns_out_if.source                   o_nrm,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hns_pkg::PADDR_W-1:0] paddr,
    input  logic [hns_pkg::PDATA_W-1:0] pwdata,
    output logic [hns_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import hns_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);

    t_cmd          cmd;
    t_sts          sts;
    logic [15:0]   height_scale;
    logic [CW-1:0] side_last;
    logic          cfg_clear;

    hns_cfg_regs #(.MAX_SIDE(MAX_SIDE)) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_height_scale (height_scale),
        .o_side_last    (side_last),
        .o_clear        (cfg_clear)
    );

    hns_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    hns_datapath #(.MAX_SIDE(MAX_SIDE)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_gray         (i_pix.gray),
        .i_height_scale (height_scale),
        .i_side_last    (side_last),
        .i_clear        (cfg_clear),
        .o_out_valid    (o_nrm.valid),
        .i_out_ready    (o_nrm.ready),
        .o_norm_x       (o_nrm.norm_x),
        .o_norm_y       (o_nrm.norm_y),
        .o_norm_z       (o_nrm.norm_z),
        .o_col_index    (o_nrm.col_index),
        .o_row_index    (o_nrm.row_index),
        .o_last         (o_nrm.last)
    );

endmodule

// ===== test/heightmap_normal_stream_tb.sv =====
module heightmap_normal_stream_tb;
    import hns_pkg::*;

    localparam int  MAX_SIDE    = MAX_SIDE_DEF;
    localparam int  DRAIN_WAIT  = 300;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  ITEM_TARGET = 370;

    typedef struct {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic        [14:0] nz;
        logic        [9:0]  col;
        logic        [9:0]  row;
        logic               last;
    } t_normal;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    hns_in_if  pix ();
    hns_out_if nrm ();

    heightmap_normal_stream u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_nrm   (nrm),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the block state used by the normal predictor.
    logic [15:0] hgt_older [MAX_SIDE];
    logic [15:0] hgt_newer [MAX_SIDE];
    logic [15:0] hgt_prev1;
    logic [15:0] hgt_prev2;
    int unsigned pos_col;
    int unsigned pos_row;
    logic [10:0] side_reg;
    logic [15:0] scale_reg;

    t_normal     normals_due[$];
    int          errors;
    int          items_sent;
    int          normals_seen;
    int          cycles;
    int          rx_wait;
    bit          no_idle;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Rounded magnitude * 16384 / sqrt(len2), found by bisection on exact squares.
    function automatic int unsigned unit_q14(longint unsigned c2, longint unsigned len2);
        longint unsigned rhs;
        longint unsigned t;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        rhs = c2 << 30;
        lo  = 0;
        hi  = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            t   = 2 * longint'(mid) - 1;
            if (t * t * len2 <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // Queue the normal of one vertex from its four clamped neighbors.
    function automatic void push_normal(int unsigned l, int unsigned r, int unsigned b,
                                        int unsigned t, int unsigned col,
                                        int unsigned row, bit lst);
        int dx;
        int dy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned len2;
        int unsigned mx;
        int unsigned my;
        t_normal n;
        dx   = int'(l) - int'(r);
        dy   = int'(t) - int'(b);
        ax   = (dx < 0) ? -dx : dx;
        ay   = (dy < 0) ? -dy : dy;
        len2 = ax * ax + ay * ay + 64'd262144;
        mx   = unit_q14(ax * ax, len2);
        my   = unit_q14(ay * ay, len2);
        n.nx   = (dx < 0) ? -16'(mx) : 16'(mx);
        n.ny   = (dy < 0) ? -16'(my) : 16'(my);
        n.nz   = 15'(unit_q14(64'd262144, len2));
        n.col  = 10'(col);
        n.row  = 10'(row);
        n.last = lst;
        normals_due.insert(normals_due.size(), n);
    endfunction

    // Advance the shadow state by one accepted grey byte.
    function automatic void predict_gray(logic [7:0] g);
        int unsigned s;
        int unsigned x;
        int unsigned r;
        int unsigned h;
        s = side_reg;
        if (s < 2) s = 2;
        if (s > MAX_SIDE) s = MAX_SIDE;
        x = pos_col;
        r = pos_row;
        if (x >= s) x = s - 1;
        if (r >= s) r = s - 1;
        h = (int'(g) * int'(scale_reg)) / 255;

        // Center one row up is now complete.
        if (r >= 1)
            push_normal(hgt_newer[(x != 0) ? x - 1 : 0],
                        hgt_newer[(x + 1 < s) ? x + 1 : x],
                        (r == 1) ? hgt_newer[x] : hgt_older[x],
                        h, x, r - 1, 1'b0);
        // The final row flushes its own centers.
        if (r == s - 1) begin
            if (x >= 1)
                push_normal((x >= 2) ? hgt_prev2 : hgt_prev1, h, hgt_newer[x - 1],
                            hgt_prev1, x - 1, r, 1'b0);
            if (x == s - 1)
                push_normal(hgt_prev1, h, hgt_newer[x], h, x, r, 1'b1);
        end

        if (x >= 1) begin
            hgt_older[x - 1] = hgt_newer[x - 1];
            hgt_newer[x - 1] = hgt_prev1;
        end
        if (x == s - 1) begin
            hgt_older[x] = hgt_newer[x];
            hgt_newer[x] = 16'(h);
        end
        hgt_prev2 = hgt_prev1;
        hgt_prev1 = 16'(h);

        if (x == s - 1) begin
            pos_col = 0;
            pos_row = (r == s - 1) ? 0 : r + 1;
        end else begin
            pos_col = x + 1;
            pos_row = r;
        end
    endfunction

    // Output ready: holds low for a randomly drawn wait after each normal.
    initial begin
        nrm.ready = 1'b0;
        rx_wait   = 0;
        forever begin
            @(negedge i_clk);
            if (rx_wait == 0) begin
                nrm.ready <= 1'b1;
            end else begin
                nrm.ready <= 1'b0;
                rx_wait   = rx_wait - 1;
            end
        end
    end

    // Compare each accepted normal against the oldest expected one.
    always @(posedge i_clk) begin
        t_normal e;
        if (i_rst_n && nrm.valid && nrm.ready) begin
            normals_seen = normals_seen + 1;
            rx_wait      = no_idle ? 0 : $urandom_range(0, 9);
            if (normals_due.size() == 0) begin
                errors = errors + 1;
                if (errors <= 10)
                    $display("Unexpected normal col %0d row %0d", nrm.col_index,
                             nrm.row_index);
            end else begin
                e = normals_due.pop_front();
                if (nrm.norm_x !== e.nx || nrm.norm_y !== e.ny || nrm.norm_z !== e.nz ||
                    nrm.col_index !== e.col || nrm.row_index !== e.row ||
                    nrm.last !== e.last) begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("Mismatch: expected x %0d y %0d z %0d c %0d r %0d l %0d, %s",
                                 e.nx, e.ny, e.nz, e.col, e.row, e.last,
                                 $sformatf("got x %0d y %0d z %0d c %0d r %0d l %0d",
                                           nrm.norm_x, nrm.norm_y, nrm.norm_z,
                                           nrm.col_index, nrm.row_index, nrm.last));
                end
            end
        end
    end

    // Send one grey byte request; starts and ends just after a falling edge.
    task automatic send_gray(logic [7:0] g);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.gray  <= g;
        do @(posedge i_clk); while (!(pix.valid && pix.ready));
        predict_gray(g);
        items_sent = items_sent + 1;
        @(negedge i_clk);
    endtask

    // Let all expected normals arrive and any hidden work finish.
    task automatic wait_idle();
        pix.valid <= 1'b0;
        while (normals_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // Register write followed by a read-back; called only when idle.
    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        logic [31:0] want;
        wait_idle();
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= val;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        want = (idx == REG_GRID_SIDE) ? (val & 32'h7FF) : (val & 32'hFFFF);
        if (prdata !== want) begin
            errors = errors + 1;
            if (errors <= 10)
                $display("Register %0d read back %0h, expected %0h", idx, prdata, want);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_GRID_SIDE) side_reg = 11'(val);
        else scale_reg = 16'(val);
        pos_col   = 0;
        pos_row   = 0;
        hgt_prev1 = '0;
        hgt_prev2 = '0;
    endtask

    function automatic logic [7:0] rand_gray();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Smallest grids with full-swing heights, zero scale and out-of-range sides.
    task automatic test_small_grids();
        write_reg(REG_HEIGHT_SCALE, 32'd65535);
        write_reg(REG_GRID_SIDE, 32'd2);
        send_gray(8'd0);
        send_gray(8'd255);
        send_gray(8'd255);
        send_gray(8'd0);
        // Second frame follows directly after the final vertex.
        send_gray(8'd255);
        send_gray(8'd0);
        send_gray(8'd0);
        send_gray(8'd255);
        write_reg(REG_HEIGHT_SCALE, 32'd0);
        write_reg(REG_GRID_SIDE, 32'd3);
        repeat (9) send_gray(8'($urandom));
        // Sides below two act as two.
        write_reg(REG_HEIGHT_SCALE, 32'd40000);
        write_reg(REG_GRID_SIDE, 32'd0);
        repeat (4) send_gray(rand_gray());
        write_reg(REG_GRID_SIDE, 32'd1);
        repeat (4) send_gray(rand_gray());
    endtask

    // Sides at and above the row store depth: only row zero fits the budget.
    task automatic test_large_sides();
        write_reg(REG_GRID_SIDE, 32'd2047);
        repeat (3) send_gray(rand_gray());
        write_reg(REG_GRID_SIDE, 32'd1024);
        repeat (20) send_gray(rand_gray());
    endtask

    // Whole frames over random small grids, with some frames cut short.
    task automatic test_random_frames();
        int s;
        int n;
        while (items_sent < ITEM_TARGET) begin
            no_idle = ($urandom_range(0, 3) == 0);
            s = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 7);
            write_reg(REG_GRID_SIDE, s);
            case ($urandom_range(0, 5))
                0: write_reg(REG_HEIGHT_SCALE, 32'd65535);
                1: write_reg(REG_HEIGHT_SCALE, 32'd0);
                default: write_reg(REG_HEIGHT_SCALE, $urandom_range(0, 65535));
            endcase
            n = s * s * $urandom_range(1, 2);
            if ($urandom_range(0, 5) == 0) n = $urandom_range(1, s * s - 1);
            // Stop at the planned number of requests.
            if (n > ITEM_TARGET - items_sent) n = ITEM_TARGET - items_sent;
            repeat (n) send_gray(rand_gray());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        errors       = 0;
        items_sent   = 0;
        normals_seen = 0;
        cycles       = 0;
        no_idle      = 1'b0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        pix.valid    = 1'b0;
        pix.gray     = '0;
        side_reg     = GRID_SIDE_RST;
        scale_reg    = HEIGHT_SCALE_RST;
        pos_col      = 0;
        pos_row      = 0;
        hgt_prev1    = '0;
        hgt_prev2    = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_small_grids();
        test_large_sides();
        test_random_frames();

        wait_idle();
        $display("Sent %0d grey bytes over grids from 2 to 1024 wide; checked %0d normals.",
                 items_sent, normals_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
